// File: hw/rtl/lps_pkg.sv
// Types and constants shared by the LED pattern sequencer modules.
// No dependencies.
`default_nettype none

package lps_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int TICK_W      = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_SHORT_ON     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHORT_PERIOD = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LONG_ON      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LONG_PERIOD  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_FAST_CYCLES  = 3'd5;

    localparam logic [TICK_W-1:0] RST_SHORT_ON     = 16'd100;
    localparam logic [TICK_W-1:0] RST_SHORT_PERIOD = 16'd200;
    localparam logic [TICK_W-1:0] RST_LONG_ON      = 16'd1000;
    localparam logic [TICK_W-1:0] RST_LONG_PERIOD  = 16'd2000;
    localparam logic [TICK_W-1:0] RST_TIMEOUT      = 16'd10000;
    localparam logic [TICK_W-1:0] RST_FAST_CYCLES  = 16'd3;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SET  = 1'b1;

    typedef enum logic [2:0] {
        PAT_IDLE     = 3'd0,
        PAT_ON       = 3'd1,
        PAT_OFF      = 3'd2,
        PAT_ONCE     = 3'd3,
        PAT_SLOW     = 3'd4,
        PAT_FAST     = 3'd5,
        PAT_FLASH    = 3'd6,
        PAT_FINISHED = 3'd7
    } pattern_t;

    typedef struct packed {
        logic [TICK_W-1:0] short_on;
        logic [TICK_W-1:0] short_period;
        logic [TICK_W-1:0] long_on;
        logic [TICK_W-1:0] long_period;
        logic [TICK_W-1:0] timeout;
        logic [TICK_W-1:0] fast_cycles;
    } cfg_t;

    typedef struct packed {
        pattern_t          pattern;
        logic [TICK_W-1:0] blink;
        logic [TICK_W-1:0] cycles;
        logic              led;
    } state_t;

    typedef struct packed {
        logic led_on;
        logic timer_restart;
        logic battery_check_clear;
    } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/lps_cfg.sv
// Configuration register bank of the LED pattern sequencer.
// Depends on lps_pkg for the register indexes, reset values and cfg_t.
`default_nettype none

module lps_cfg
    import lps_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   wr_en,
    input  wire logic [CFG_INDEX_W-1:0] wr_index,
    input  wire logic [TICK_W-1:0]      wr_data,
    output cfg_t                        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                CFG_SHORT_ON:     cfg_next.short_on     = wr_data;
                CFG_SHORT_PERIOD: cfg_next.short_period = wr_data;
                CFG_LONG_ON:      cfg_next.long_on      = wr_data;
                CFG_LONG_PERIOD:  cfg_next.long_period  = wr_data;
                CFG_TIMEOUT:      cfg_next.timeout      = wr_data;
                CFG_FAST_CYCLES:  cfg_next.fast_cycles  = wr_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_on     <= RST_SHORT_ON;
            cfg_reg.short_period <= RST_SHORT_PERIOD;
            cfg_reg.long_on      <= RST_LONG_ON;
            cfg_reg.long_period  <= RST_LONG_PERIOD;
            cfg_reg.timeout      <= RST_TIMEOUT;
            cfg_reg.fast_cycles  <= RST_FAST_CYCLES;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: hw/rtl/lps_step.sv
// Next-state and result logic for one beat of the LED pattern sequencer.
// Depends on lps_pkg for pattern codes, cfg_t, state_t and result_t.
`default_nettype none

module lps_step
    import lps_pkg::*;
(
    input  wire cfg_t              cfg,
    input  wire state_t            state_cur,
    input  wire logic              opcode,
    input  wire logic [2:0]        new_pattern,
    input  wire logic [TICK_W-1:0] elapsed_ticks,
    output state_t                 state_nxt,
    output result_t                res
);

    typedef struct packed {
        logic              led;
        logic [TICK_W-1:0] count;
        logic              done;
    } blink_t;

    function automatic blink_t blink_step(input logic [TICK_W-1:0] cnt,
                                          input logic              led,
                                          input logic [TICK_W-1:0] on_last,
                                          input logic [TICK_W-1:0] period_last);
        blink_t            r;
        logic [TICK_W-1:0] inc;
        r.led = led;
        if (cnt <= on_last)
        begin
            r.led = 1'b1;
        end
        else if (cnt <= period_last)
        begin
            r.led = 1'b0;
        end
        inc     = cnt + {{(TICK_W-1){1'b0}}, 1'b1};
        r.count = inc;
        r.done  = 1'b0;
        if (period_last < inc)
        begin
            r.count = '0;
            r.done  = 1'b1;
        end
        return r;
    endfunction

    blink_t slow_b;
    blink_t fast_b;

    assign slow_b = blink_step(state_cur.blink, state_cur.led, cfg.long_on, cfg.long_period);
    assign fast_b = blink_step(state_cur.blink, state_cur.led, cfg.short_on, cfg.short_period);

    always_comb
    begin
        state_nxt               = state_cur;
        res.timer_restart       = 1'b0;
        res.battery_check_clear = 1'b0;
        if (opcode == OP_SET)
        begin
            state_nxt.pattern = pattern_t'(new_pattern);
            state_nxt.blink   = '0;
            state_nxt.cycles  = '0;
            res.timer_restart = 1'b1;
        end
        else if (elapsed_ticks < cfg.timeout)
        begin
            case (state_cur.pattern)
                PAT_ON:
                begin
                    state_nxt.led = 1'b1;
                end
                PAT_OFF:
                begin
                    state_nxt.led = 1'b0;
                end
                PAT_ONCE:
                begin
                    if (!state_cur.led)
                    begin
                        state_nxt.led     = 1'b1;
                        state_nxt.pattern = PAT_FINISHED;
                    end
                end
                PAT_SLOW:
                begin
                    state_nxt.led   = slow_b.led;
                    state_nxt.blink = slow_b.count;
                end
                PAT_FAST:
                begin
                    if (state_cur.cycles < cfg.fast_cycles)
                    begin
                        state_nxt.led   = fast_b.led;
                        state_nxt.blink = fast_b.count;
                        if (fast_b.done)
                        begin
                            state_nxt.cycles = state_cur.cycles + {{(TICK_W-1){1'b0}}, 1'b1};
                        end
                    end
                end
                PAT_FLASH:
                begin
                    if (state_cur.blink <= cfg.short_on)
                    begin
                        state_nxt.led = 1'b1;
                    end
                    else if (state_cur.led)
                    begin
                        state_nxt.led     = 1'b0;
                        state_nxt.pattern = PAT_FINISHED;
                    end
                    if (state_cur.blink != {TICK_W{1'b1}})
                    begin
                        state_nxt.blink = state_cur.blink + {{(TICK_W-1){1'b0}}, 1'b1};
                    end
                end
                default:
                begin
                    state_nxt = state_cur;
                end
            endcase
        end
        else if (state_cur.pattern != PAT_IDLE && state_cur.pattern != PAT_ON)
        begin
            state_nxt.pattern       = PAT_IDLE;
            state_nxt.led           = 1'b0;
            res.battery_check_clear = 1'b1;
        end
        res.led_on = state_nxt.led;
    end

endmodule

`default_nettype wire

// File: hw/rtl/led_pattern_sequencer.sv
// Top level of the LED pattern sequencer: input register, state, result register.
// Depends on lps_pkg, lps_cfg and lps_step.
//
//   channel | handshake            | beat contents
//   --------+----------------------+------------------------------------------
//   in      | in_valid / in_ready  | opcode, new_pattern, elapsed_ticks
//   out     | out_valid / out_ready| led_on, timer_restart, battery_check_clear
//   cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One beat per cycle while out is not stalled; a beat is registered on entry
// in the input register, stepped against the pattern state and held in the
// result register for out. The state update of the step stage sets the rate.
// Reset clears the pattern state and loads the configuration defaults.
// A stalled out channel holds the result register, then the input register.
`default_nettype none

module led_pattern_sequencer
    import lps_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   in_valid,
    output wire logic                   in_ready,
    input  wire logic                   opcode,
    input  wire logic [2:0]             new_pattern,
    input  wire logic [TICK_W-1:0]      elapsed_ticks,

    output wire logic                   out_valid,
    input  wire logic                   out_ready,
    output wire logic                   led_on,
    output wire logic                   timer_restart,
    output wire logic                   battery_check_clear,

    input  wire logic                   cfg_valid,
    output wire logic                   cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [TICK_W-1:0]      cfg_data
);

    cfg_t              cfg;
    state_t            state_reg;
    state_t            state_next;
    result_t           res_next;
    result_t           res_reg;
    logic              in_vld_reg;
    logic              out_vld_reg;
    logic              op_reg;
    logic [2:0]        pat_reg;
    logic [TICK_W-1:0] elapsed_reg;
    logic              adv;
    logic              take;

    assign cfg_ready = 1'b1;

    lps_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    lps_step u_step (
        .cfg           (cfg),
        .state_cur     (state_reg),
        .opcode        (op_reg),
        .new_pattern   (pat_reg),
        .elapsed_ticks (elapsed_reg),
        .state_nxt     (state_next),
        .res           (res_next)
    );

    assign adv      = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || adv;
    assign take     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg        <= 1'b0;
            out_vld_reg       <= 1'b0;
            state_reg.pattern <= PAT_IDLE;
            state_reg.blink   <= '0;
            state_reg.cycles  <= '0;
            state_reg.led     <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (adv)
            begin
                in_vld_reg <= 1'b0;
            end
            if (adv)
            begin
                out_vld_reg <= 1'b1;
                state_reg   <= state_next;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            op_reg      <= opcode;
            pat_reg     <= new_pattern;
            elapsed_reg <= elapsed_ticks;
        end
        if (adv)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid           = out_vld_reg;
    assign led_on              = res_reg.led_on;
    assign timer_restart       = res_reg.timer_restart;
    assign battery_check_clear = res_reg.battery_check_clear;

    a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && out_vld_reg && !out_ready) |-> !in_ready)
        else $error("input taken while both stages are stalled");

    a_restart_xor_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(timer_restart && battery_check_clear))
        else $error("restart and clear pulsed on the same beat");

    a_clear_led_off: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && battery_check_clear) |-> !led_on)
        else $error("LED lit on a timeout beat");

    a_clear_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && res_next.battery_check_clear) |=> (state_reg.pattern == PAT_IDLE))
        else $error("timeout did not return the pattern to idle");

    a_set_clears_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && op_reg == OP_SET) |=> (state_reg.blink == '0 && state_reg.cycles == '0))
        else $error("set beat left counters nonzero");

endmodule

`default_nettype wire
